>>> hdl/evt_pkg.sv
// Shared types, widths and saturation helpers for the Euler vertex transform.
// Used by every module of the block; depends on nothing.
package evt_pkg;

	// Field widths of the vertex and of the rotation coefficients.
	localparam int POS_W     = 32;
	localparam int NORM_W    = 16;
	localparam int TRIG_W    = 16;
	localparam int TRIG_FRAC = TRIG_W - 2;

	// Configuration port widths.
	localparam int CFG_W     = (2 * TRIG_W > POS_W) ? 2 * TRIG_W : POS_W;
	localparam int CFG_IDX_W = 3;

	// Product, sum and post-shift widths of the rotation arithmetic.
	localparam int PPROD_W = POS_W + TRIG_W;
	localparam int PSUM_W  = PPROD_W + 1;
	localparam int PSH_W   = PSUM_W - TRIG_FRAC;
	localparam int NPROD_W = NORM_W + TRIG_W;
	localparam int NSUM_W  = NPROD_W + 1;
	localparam int NSH_W   = NSUM_W - TRIG_FRAC;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROT_X  = 3'd0,
		REG_ROT_Y  = 3'd1,
		REG_ROT_Z  = 3'd2,
		REG_OFF_X  = 3'd3,
		REG_OFF_Y  = 3'd4,
		REG_OFF_Z  = 3'd5
	} cfg_idx_t;

	// Configuration register contents.
	typedef struct packed {
		logic [2*TRIG_W-1:0]      rot_x;
		logic [2*TRIG_W-1:0]      rot_y;
		logic [2*TRIG_W-1:0]      rot_z;
		logic signed [POS_W-1:0]  off_x;
		logic signed [POS_W-1:0]  off_y;
		logic signed [POS_W-1:0]  off_z;
	} cfg_t;

	// A whole vertex as it travels between stages.
	typedef struct packed {
		logic signed [POS_W-1:0]  px;
		logic signed [POS_W-1:0]  py;
		logic signed [POS_W-1:0]  pz;
		logic signed [NORM_W-1:0] nx;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nz;
		logic                     last;
	} vtx_t;

	// A vertex seen by one rotation: the rotated pair (a, b) and the kept axis k.
	typedef struct packed {
		logic signed [POS_W-1:0]  pa;
		logic signed [POS_W-1:0]  pb;
		logic signed [POS_W-1:0]  pk;
		logic signed [NORM_W-1:0] na;
		logic signed [NORM_W-1:0] nb;
		logic signed [NORM_W-1:0] nk;
		logic                     last;
	} rot_pair_t;

	// Reset value of a rotation register: cosine one, sine zero.
	localparam logic [2*TRIG_W-1:0] TRIG_RESET = {2'b01, {(2*TRIG_W-2){1'b0}}};

	// Saturate a shifted position sum to the position width.
	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PSH_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if ((&v[PSH_W-1:POS_W-1]) || !(|v[PSH_W-1:POS_W-1])) begin
			r = v[POS_W-1:0];
		end else if (v[PSH_W-1]) begin
			r = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(POS_W-1){1'b1}}};
		end
		return r;
	endfunction

	// Saturate a shifted normal sum to the normal width.
	function automatic logic signed [NORM_W-1:0] sat_norm(input logic signed [NSH_W-1:0] v);
		logic signed [NORM_W-1:0] r;
		if ((&v[NSH_W-1:NORM_W-1]) || !(|v[NSH_W-1:NORM_W-1])) begin
			r = v[NORM_W-1:0];
		end else if (v[NSH_W-1]) begin
			r = {1'b1, {(NORM_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(NORM_W-1){1'b1}}};
		end
		return r;
	endfunction

	// Saturate a position plus offset, one bit wider than a position.
	function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W:0] v);
		logic signed [POS_W-1:0] r;
		if (v[POS_W] == v[POS_W-1]) begin
			r = v[POS_W-1:0];
		end else if (v[POS_W]) begin
			r = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(POS_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

>>> hdl/euler_vertex_transform_unit.sv
// Euler vertex transform: rotation about x, then y, then z, then translation.
// Each axis rotation registers its products, then its sums after shift and saturate,
// and the offset add has its own output register.
// Throughput is one vertex per cycle while out_stall is low; each stage advances
// whenever it is empty or its successor moves, so bubbles are squeezed out under stall.
// Reset clears all valid bits and loads identity rotations and zero offsets.
module euler_vertex_transform_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [evt_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [evt_pkg::CFG_W-1:0]         wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [evt_pkg::POS_W-1:0]  pos_x,
	input  logic signed [evt_pkg::POS_W-1:0]  pos_y,
	input  logic signed [evt_pkg::POS_W-1:0]  pos_z,
	input  logic signed [evt_pkg::NORM_W-1:0] norm_x,
	input  logic signed [evt_pkg::NORM_W-1:0] norm_y,
	input  logic signed [evt_pkg::NORM_W-1:0] norm_z,
	input  logic                              last_vertex,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [evt_pkg::POS_W-1:0]  out_pos_x,
	output logic signed [evt_pkg::POS_W-1:0]  out_pos_y,
	output logic signed [evt_pkg::POS_W-1:0]  out_pos_z,
	output logic signed [evt_pkg::NORM_W-1:0] out_norm_x,
	output logic signed [evt_pkg::NORM_W-1:0] out_norm_y,
	output logic signed [evt_pkg::NORM_W-1:0] out_norm_z,
	output logic                              out_last
);
	import evt_pkg::*;

	cfg_t      cfg;
	rot_pair_t x_in, x_out, y_in, y_out, z_in, z_out;
	logic      x_valid, y_valid, z_valid;
	logic      y_stall, z_stall, t_stall;
	vtx_t      t_in, t_out;

	// Configuration registers.
	evt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// Rotation about x rotates (y, z) and keeps x.
	assign x_in.pa   = pos_y;
	assign x_in.pb   = pos_z;
	assign x_in.pk   = pos_x;
	assign x_in.na   = norm_y;
	assign x_in.nb   = norm_z;
	assign x_in.nk   = norm_x;
	assign x_in.last = last_vertex;

	evt_rotate u_rot_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.trig     (cfg.rot_x),
		.up_valid (in_valid),
		.up_pair  (x_in),
		.up_stall (in_stall),
		.dn_valid (x_valid),
		.dn_pair  (x_out),
		.dn_stall (y_stall)
	);

	// Rotation about y rotates (z, x) and keeps y.
	assign y_in.pa   = x_out.pb;
	assign y_in.pb   = x_out.pk;
	assign y_in.pk   = x_out.pa;
	assign y_in.na   = x_out.nb;
	assign y_in.nb   = x_out.nk;
	assign y_in.nk   = x_out.na;
	assign y_in.last = x_out.last;

	evt_rotate u_rot_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.trig     (cfg.rot_y),
		.up_valid (x_valid),
		.up_pair  (y_in),
		.up_stall (y_stall),
		.dn_valid (y_valid),
		.dn_pair  (y_out),
		.dn_stall (z_stall)
	);

	// Rotation about z rotates (x, y) and keeps z.
	assign z_in.pa   = y_out.pb;
	assign z_in.pb   = y_out.pk;
	assign z_in.pk   = y_out.pa;
	assign z_in.na   = y_out.nb;
	assign z_in.nb   = y_out.nk;
	assign z_in.nk   = y_out.na;
	assign z_in.last = y_out.last;

	evt_rotate u_rot_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.trig     (cfg.rot_z),
		.up_valid (y_valid),
		.up_pair  (z_in),
		.up_stall (z_stall),
		.dn_valid (z_valid),
		.dn_pair  (z_out),
		.dn_stall (t_stall)
	);

	// Back to x, y, z order for the translation.
	assign t_in.px   = z_out.pa;
	assign t_in.py   = z_out.pb;
	assign t_in.pz   = z_out.pk;
	assign t_in.nx   = z_out.na;
	assign t_in.ny   = z_out.nb;
	assign t_in.nz   = z_out.nk;
	assign t_in.last = z_out.last;

	evt_translate u_translate (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (z_valid),
		.up_vtx   (t_in),
		.up_stall (t_stall),
		.dn_valid (out_valid),
		.dn_vtx   (t_out),
		.dn_stall (out_stall)
	);

	// Result fields.
	assign out_pos_x  = t_out.px;
	assign out_pos_y  = t_out.py;
	assign out_pos_z  = t_out.pz;
	assign out_norm_x = t_out.nx;
	assign out_norm_y = t_out.ny;
	assign out_norm_z = t_out.nz;
	assign out_last   = t_out.last;

endmodule

>>> hdl/evt_cfg.sv
// Configuration register bank of the vertex transform.
// Depends on evt_pkg for the register indexes and the cfg_t layout.
module evt_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [evt_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [evt_pkg::CFG_W-1:0]     wr_data,
	output evt_pkg::cfg_t                cfg
);
	import evt_pkg::*;

	cfg_t cfg_q;

	// Decode the register index and capture the write; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_x <= TRIG_RESET;
			cfg_q.rot_y <= TRIG_RESET;
			cfg_q.rot_z <= TRIG_RESET;
			cfg_q.off_x <= '0;
			cfg_q.off_y <= '0;
			cfg_q.off_z <= '0;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				REG_ROT_X: cfg_q.rot_x <= wr_data[2*TRIG_W-1:0];
				REG_ROT_Y: cfg_q.rot_y <= wr_data[2*TRIG_W-1:0];
				REG_ROT_Z: cfg_q.rot_z <= wr_data[2*TRIG_W-1:0];
				REG_OFF_X: cfg_q.off_x <= wr_data[POS_W-1:0];
				REG_OFF_Y: cfg_q.off_y <= wr_data[POS_W-1:0];
				REG_OFF_Z: cfg_q.off_z <= wr_data[POS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/evt_rotate.sv
// One axis rotation in two pipeline stages: products, then sum, shift and saturate.
// Depends on evt_pkg for widths, rot_pair_t and the saturation helpers.
module evt_rotate (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [2*evt_pkg::TRIG_W-1:0] trig,
	input  logic                      up_valid,
	input  evt_pkg::rot_pair_t        up_pair,
	output logic                      up_stall,
	output logic                      dn_valid,
	output evt_pkg::rot_pair_t        dn_pair,
	input  logic                      dn_stall
);
	import evt_pkg::*;

	logic signed [TRIG_W-1:0]  cos_v;
	logic signed [TRIG_W-1:0]  sin_v;
	logic                      en_s1;
	logic                      en_s2;

	logic                      v_s1;
	logic signed [PPROD_W-1:0] pac_s1, pbs_s1, pas_s1, pbc_s1;
	logic signed [NPROD_W-1:0] nac_s1, nbs_s1, nas_s1, nbc_s1;
	logic signed [POS_W-1:0]   pk_s1;
	logic signed [NORM_W-1:0]  nk_s1;
	logic                      last_s1;

	logic signed [PSUM_W-1:0]  pa_sum, pb_sum;
	logic signed [NSUM_W-1:0]  na_sum, nb_sum;

	logic                      v_s2;
	rot_pair_t                 pair_s2;

	assign cos_v = trig[2*TRIG_W-1:TRIG_W];
	assign sin_v = trig[TRIG_W-1:0];

	// A stage takes a new request when it is empty or its contents move on.
	assign en_s2    = !v_s2 || !dn_stall;
	assign en_s1    = !v_s1 || en_s2;
	assign up_stall = !en_s1;

	// Stage one: the eight products of the pair with cosine and sine.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pac_s1  <= PPROD_W'(up_pair.pa) * PPROD_W'(cos_v);
			pbs_s1  <= PPROD_W'(up_pair.pb) * PPROD_W'(sin_v);
			pas_s1  <= PPROD_W'(up_pair.pa) * PPROD_W'(sin_v);
			pbc_s1  <= PPROD_W'(up_pair.pb) * PPROD_W'(cos_v);
			nac_s1  <= NPROD_W'(up_pair.na) * NPROD_W'(cos_v);
			nbs_s1  <= NPROD_W'(up_pair.nb) * NPROD_W'(sin_v);
			nas_s1  <= NPROD_W'(up_pair.na) * NPROD_W'(sin_v);
			nbc_s1  <= NPROD_W'(up_pair.nb) * NPROD_W'(cos_v);
			pk_s1   <= up_pair.pk;
			nk_s1   <= up_pair.nk;
			last_s1 <= up_pair.last;
		end
	end

	// Exact sums of the products: a' = a*c - b*s, b' = a*s + b*c.
	assign pa_sum = PSUM_W'(pac_s1) - PSUM_W'(pbs_s1);
	assign pb_sum = PSUM_W'(pas_s1) + PSUM_W'(pbc_s1);
	assign na_sum = NSUM_W'(nac_s1) - NSUM_W'(nbs_s1);
	assign nb_sum = NSUM_W'(nas_s1) + NSUM_W'(nbc_s1);

	// Stage two: drop the fraction bits (floor) and saturate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			pair_s2.pa   <= sat_pos(pa_sum[PSUM_W-1:TRIG_FRAC]);
			pair_s2.pb   <= sat_pos(pb_sum[PSUM_W-1:TRIG_FRAC]);
			pair_s2.pk   <= pk_s1;
			pair_s2.na   <= sat_norm(na_sum[NSUM_W-1:TRIG_FRAC]);
			pair_s2.nb   <= sat_norm(nb_sum[NSUM_W-1:TRIG_FRAC]);
			pair_s2.nk   <= nk_s1;
			pair_s2.last <= last_s1;
		end
	end

	assign dn_valid = v_s2;
	assign dn_pair  = pair_s2;

endmodule

>>> hdl/evt_translate.sv
// Final stage: adds the configured offset to the position with saturation.
// Depends on evt_pkg for vtx_t, cfg_t and sat_add.
module evt_translate (
	input  logic          clk,
	input  logic          arst_n,
	input  evt_pkg::cfg_t cfg,
	input  logic          up_valid,
	input  evt_pkg::vtx_t up_vtx,
	output logic          up_stall,
	output logic          dn_valid,
	output evt_pkg::vtx_t dn_vtx,
	input  logic          dn_stall
);
	import evt_pkg::*;

	logic            en_s1;
	logic            v_s1;
	vtx_t            vtx_s1;
	logic [POS_W:0]  sum_x, sum_y, sum_z;

	assign en_s1    = !v_s1 || !dn_stall;
	assign up_stall = !en_s1;

	// Position plus offset, one bit wider so that overflow can be seen.
	assign sum_x = (POS_W+1)'(up_vtx.px) + (POS_W+1)'(cfg.off_x);
	assign sum_y = (POS_W+1)'(up_vtx.py) + (POS_W+1)'(cfg.off_y);
	assign sum_z = (POS_W+1)'(up_vtx.pz) + (POS_W+1)'(cfg.off_z);

	// Output register; the normal and the last flag pass unchanged.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			vtx_s1.px   <= sat_add(sum_x);
			vtx_s1.py   <= sat_add(sum_y);
			vtx_s1.pz   <= sat_add(sum_z);
			vtx_s1.nx   <= up_vtx.nx;
			vtx_s1.ny   <= up_vtx.ny;
			vtx_s1.nz   <= up_vtx.nz;
			vtx_s1.last <= up_vtx.last;
		end
	end

	assign dn_valid = v_s1;
	assign dn_vtx   = vtx_s1;

endmodule

>>> sim/euler_vertex_transform_unit_tb.sv
// Self-checking testbench for the Euler vertex transform unit.
// Depends on evt_pkg and euler_vertex_transform_unit; runs directed corners,
// then random vertices under three idling regimes with randomised registers.
module euler_vertex_transform_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import evt_pkg::*;

	// Register indexes beyond the last real register; writes there must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(REG_OFF_Z + 1);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = {CFG_IDX_W{1'b1}};

	localparam logic [POS_W-1:0]  POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic [POS_W-1:0]  POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic [NORM_W-1:0] NORM_ONE = 16'sh4000;
	localparam logic [NORM_W-1:0] NORM_MAX = 16'sh7FFF;
	localparam logic [NORM_W-1:0] NORM_MIN = 16'sh8000;

	localparam int SETTLE_CYCLES  = 12;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int REPORT_LIMIT   = 10;

	// Tracks the register file, predicts each transformed vertex and checks results.
	class vertex_scoreboard;
		cfg_t regs;
		vtx_t awaited_vertices[$];
		int mismatches;
		int results_seen;

		function new();
			regs = '{TRIG_RESET, TRIG_RESET, TRIG_RESET, '0, '0, '0};
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_ROT_X: regs.rot_x = data[2*TRIG_W-1:0];
				REG_ROT_Y: regs.rot_y = data[2*TRIG_W-1:0];
				REG_ROT_Z: regs.rot_z = data[2*TRIG_W-1:0];
				REG_OFF_X: regs.off_x = data[POS_W-1:0];
				REG_OFF_Y: regs.off_y = data[POS_W-1:0];
				REG_OFF_Z: regs.off_z = data[POS_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp(longint v, int w);
			longint hi;
			hi = (longint'(1) << (w - 1)) - 1;
			if (v > hi) return hi;
			if (v < -hi - 1) return -hi - 1;
			return v;
		endfunction

		// Exact sum of two products, floored by the trig fraction, then saturated.
		function longint scaled_sum(longint a, longint ta, longint b, longint tb, int w);
			return clamp((a * ta + b * tb) >>> TRIG_FRAC, w);
		endfunction

		function void split_trig(logic [2*TRIG_W-1:0] r, output longint c, output longint s);
			logic signed [TRIG_W-1:0] hc, hs;
			hc = r[2*TRIG_W-1:TRIG_W];
			hs = r[TRIG_W-1:0];
			c = hc;
			s = hs;
		endfunction

		// Rotate about x, then y, then z; translate the position only.
		function vtx_t transform_vertex(vtx_t v);
			longint px, py, pz, nx, ny, nz, c, s, t1, t2;
			vtx_t r;
			px = $signed(v.px);
			py = $signed(v.py);
			pz = $signed(v.pz);
			nx = $signed(v.nx);
			ny = $signed(v.ny);
			nz = $signed(v.nz);

			split_trig(regs.rot_x, c, s);
			t1 = scaled_sum(py, c, pz, -s, POS_W);
			t2 = scaled_sum(py, s, pz, c, POS_W);
			py = t1;
			pz = t2;
			t1 = scaled_sum(ny, c, nz, -s, NORM_W);
			t2 = scaled_sum(ny, s, nz, c, NORM_W);
			ny = t1;
			nz = t2;

			split_trig(regs.rot_y, c, s);
			t1 = scaled_sum(px, c, pz, s, POS_W);
			t2 = scaled_sum(px, -s, pz, c, POS_W);
			px = t1;
			pz = t2;
			t1 = scaled_sum(nx, c, nz, s, NORM_W);
			t2 = scaled_sum(nx, -s, nz, c, NORM_W);
			nx = t1;
			nz = t2;

			split_trig(regs.rot_z, c, s);
			t1 = scaled_sum(px, c, py, -s, POS_W);
			t2 = scaled_sum(px, s, py, c, POS_W);
			px = t1;
			py = t2;
			t1 = scaled_sum(nx, c, ny, -s, NORM_W);
			t2 = scaled_sum(nx, s, ny, c, NORM_W);
			nx = t1;
			ny = t2;

			px = clamp(px + longint'($signed(regs.off_x)), POS_W);
			py = clamp(py + longint'($signed(regs.off_y)), POS_W);
			pz = clamp(pz + longint'($signed(regs.off_z)), POS_W);

			r.px = px[POS_W-1:0];
			r.py = py[POS_W-1:0];
			r.pz = pz[POS_W-1:0];
			r.nx = nx[NORM_W-1:0];
			r.ny = ny[NORM_W-1:0];
			r.nz = nz[NORM_W-1:0];
			r.last = v.last;
			return r;
		endfunction

		// Queue the predicted result at the tail.
		function void note_request(vtx_t v);
			awaited_vertices.insert(awaited_vertices.size(), transform_vertex(v));
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= REPORT_LIMIT) $display("%s", msg);
		endfunction

		function void compare_field(string name, longint e, longint a);
			if (e != a) begin
				report($sformatf("result %0d %s: expected %0d, got %0d",
					results_seen, name, e, a));
			end
		endfunction

		function void check_result(vtx_t got);
			vtx_t exp_v;
			results_seen++;
			if (awaited_vertices.size() == 0) begin
				report($sformatf("result %0d arrived with no request outstanding",
					results_seen));
			end else begin
				exp_v = awaited_vertices.pop_front();
				compare_field("out_pos_x", $signed(exp_v.px), $signed(got.px));
				compare_field("out_pos_y", $signed(exp_v.py), $signed(got.py));
				compare_field("out_pos_z", $signed(exp_v.pz), $signed(got.pz));
				compare_field("out_norm_x", $signed(exp_v.nx), $signed(got.nx));
				compare_field("out_norm_y", $signed(exp_v.ny), $signed(got.ny));
				compare_field("out_norm_z", $signed(exp_v.nz), $signed(got.nz));
				compare_field("out_last", exp_v.last, got.last);
			end
		endfunction

		function int pending_count();
			return awaited_vertices.size();
		endfunction

		function int failures();
			return mismatches + awaited_vertices.size();
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]     wr_index = '0;
	logic [CFG_W-1:0]         wr_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [POS_W-1:0]  pos_x = '0;
	logic signed [POS_W-1:0]  pos_y = '0;
	logic signed [POS_W-1:0]  pos_z = '0;
	logic signed [NORM_W-1:0] norm_x = '0;
	logic signed [NORM_W-1:0] norm_y = '0;
	logic signed [NORM_W-1:0] norm_z = '0;
	logic                     last_vertex = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [POS_W-1:0]  out_pos_x;
	logic signed [POS_W-1:0]  out_pos_y;
	logic signed [POS_W-1:0]  out_pos_z;
	logic signed [NORM_W-1:0] out_norm_x;
	logic signed [NORM_W-1:0] out_norm_y;
	logic signed [NORM_W-1:0] out_norm_z;
	logic                     out_last;

	vertex_scoreboard sb = new();
	int send_gap_pct = 27;
	int recv_stall_pct = 71;
	int quiet_cycles = 0;
	logic [CFG_W-1:0] cfg_vals [6];

	euler_vertex_transform_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.norm_x(norm_x),
		.norm_y(norm_y),
		.norm_z(norm_z),
		.last_vertex(last_vertex),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_pos_x(out_pos_x),
		.out_pos_y(out_pos_y),
		.out_pos_z(out_pos_z),
		.out_norm_x(out_norm_x),
		.out_norm_y(out_norm_y),
		.out_norm_z(out_norm_z),
		.out_last(out_last)
	);

	// Free-running clock, 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The result side stalls at random at the current rate.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Observe every handshake: register writes, requests and results; also the watchdog.
	always @(posedge clk) begin : observe
		logic took_in, took_out;
		took_in = in_valid && !in_stall;
		took_out = out_valid && !out_stall;
		if (arst_n) begin
			if (wr_en) sb.write_reg(wr_index, wr_data);
			if (took_in) begin
				sb.note_request(vtx_t'{pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
					last_vertex});
			end
			if (took_out) begin
				sb.check_result(vtx_t'{out_pos_x, out_pos_y, out_pos_z, out_norm_x,
					out_norm_y, out_norm_z, out_last});
			end
			quiet_cycles = (took_in || took_out) ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[euler_vertex_transform_unit] ERROR");
				$finish;
			end
		end
	end

	function automatic logic [CFG_W-1:0] pick_one(logic [CFG_W-1:0] a, logic [CFG_W-1:0] b,
			logic [CFG_W-1:0] c, logic [CFG_W-1:0] d);
		case ($urandom_range(3))
			0: return a;
			1: return b;
			2: return c;
			default: return d;
		endcase
	endfunction

	// Positions and offsets: full range, small values, near the limits, corners.
	function automatic logic [POS_W-1:0] rand_pos();
		case ($urandom_range(7))
			0, 1, 2: return $urandom;
			3, 4: return 32'($urandom_range(2097151)) - 32'd1048576;
			5: return $urandom_range(1) ? POS_MAX - $urandom_range(65535)
				: POS_MIN + $urandom_range(65535);
			default: return pick_one(POS_MAX, POS_MIN, '0, '1);
		endcase
	endfunction

	// Normals: mostly unit range, some arbitrary patterns and corners.
	function automatic logic [NORM_W-1:0] rand_norm();
		case ($urandom_range(7))
			0: return 16'($urandom);
			1: return 16'(pick_one(NORM_ONE, -NORM_ONE, NORM_MAX, NORM_MIN));
			default: return 16'($urandom_range(32768)) - 16'd16384;
		endcase
	endfunction

	// Present one request and hold it until it is taken.
	task automatic send_vertex(input vtx_t v);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= v.px;
		pos_y <= v.py;
		pos_z <= v.pz;
		norm_x <= v.nx;
		norm_y <= v.ny;
		norm_z <= v.nz;
		last_vertex <= v.last;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop sending and wait until every predicted result has been checked. It waits
	// for a clock edge first so that the request taken at the last edge has been noted.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_count() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all six registers, and optionally both unused indexes with junk.
	task automatic load_config(input logic [CFG_W-1:0] vals [6], input bit poke_spare);
		for (int i = REG_ROT_X; i <= REG_OFF_Z; i++) begin
			wr_en <= 1'b1;
			wr_index <= CFG_IDX_W'(i);
			wr_data <= vals[i];
			@(posedge clk);
		end
		if (poke_spare) begin
			for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++) begin
				wr_en <= 1'b1;
				wr_index <= CFG_IDX_W'(i);
				wr_data <= $urandom;
				@(posedge clk);
			end
		end
		wr_en <= 1'b0;
	endtask

	// Corner vertices: field extremes, normals beyond unit length, both last values.
	task automatic send_corner_set();
		send_vertex(vtx_t'{'0, '0, '0, '0, '0, '0, 1'b0});
		send_vertex(vtx_t'{POS_MAX, POS_MIN, POS_MAX, NORM_ONE, -NORM_ONE, NORM_ONE, 1'b1});
		send_vertex(vtx_t'{POS_MIN, POS_MAX, POS_MIN, NORM_MAX, NORM_MIN, '1, 1'b0});
		send_vertex(vtx_t'{'1, 32'sd1, 32'sh0001_0000, -NORM_ONE, NORM_MIN, NORM_MAX, 1'b1});
		send_vertex(vtx_t'{32'sh1234_5678, 32'shEDCB_A987, 32'sh7FFF_0000, 16'sh2D41,
			16'shD2BF, '0, 1'b0});
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: identity after reset, then saturating, quarter-turn and
		// oblique rotations with extreme offsets.
		send_corner_set();
		wait_idle();
		cfg_vals = '{32'h7FFF_8000, 32'h8000_7FFF, 32'h8000_8000, POS_MAX, POS_MIN, POS_MAX};
		load_config(cfg_vals, 1'b1);
		send_corner_set();
		wait_idle();
		cfg_vals = '{32'h0000_4000, 32'h0000_C000, 32'hC000_0000, POS_MIN, 32'h0001_0000, '1};
		load_config(cfg_vals, 1'b0);
		send_corner_set();
		wait_idle();
		cfg_vals = '{32'h2D41_2D41, 32'h3B21_187E, 32'h187E_C4DF, 32'h7FFF_0000,
			32'h8001_0000, 32'h1234_5678};
		load_config(cfg_vals, 1'b1);
		send_corner_set();

		// Random part: three idling regimes, four register settings in each.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_gap_pct = 27;
					recv_stall_pct = 71;
				end
				1: begin
					send_gap_pct = 71;
					recv_stall_pct = 27;
				end
				default: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				wait_idle();
				for (int i = REG_ROT_X; i <= REG_OFF_Z; i++) begin
					if (i <= REG_ROT_Z) begin
						case ($urandom_range(3))
							0: cfg_vals[i] = $urandom;
							1: cfg_vals[i] = {16'(pick_one(16'h7FFF, 16'h8000, 16'h4000, 16'hC000)),
								16'(pick_one(16'h7FFF, 16'h8000, 16'h0000, 16'hC000))};
							default: cfg_vals[i] = {16'($urandom_range(32768)) - 16'd16384,
								16'($urandom_range(32768)) - 16'd16384};
						endcase
					end else begin
						cfg_vals[i] = rand_pos();
					end
				end
				load_config(cfg_vals, $urandom_range(1));
				repeat (140) begin
					send_vertex(vtx_t'{rand_pos(), rand_pos(), rand_pos(), rand_norm(),
						rand_norm(), rand_norm(), $urandom_range(7) == 0});
				end
			end
		end

		wait_idle();
		if (sb.failures() == 0) begin
			$display("[euler_vertex_transform_unit] OK");
		end else begin
			$display("[euler_vertex_transform_unit] ERROR");
		end
		$finish;
	end

endmodule
